/* design/lwb_pkg.sv */
// Shared types and constants for the link watchdog with reconnect backoff.
// Used by lwb_regs, lwb_core and link_watchdog_backoff_core; no dependencies.
package lwb_pkg;

	localparam int unsigned CfgWidth  = 10;
	localparam int unsigned TimeWidth = 32;
	localparam int unsigned CntWidth  = 8;
	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	localparam logic [CfgWidth-1:0] BackoffMinRst = 10'd1;
	localparam logic [CfgWidth-1:0] BackoffMaxRst = 10'd60;
	localparam logic [CfgWidth-1:0] FirstDataRst  = 10'd10;
	localparam logic [CfgWidth-1:0] DisconnRst    = 10'd3;

	typedef enum logic [1:0] {
		REG_BACKOFF_MIN = 2'd0,
		REG_BACKOFF_MAX = 2'd1,
		REG_FIRST_DATA  = 2'd2,
		REG_DISCONNECT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_RESET   = 3'd1,
		OP_RETRY   = 3'd2,
		OP_ATTEMPT = 3'd3,
		OP_DATA    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_STARTING  = 3'd1,
		ST_STREAMING = 3'd2,
		ST_LOST      = 3'd3,
		ST_RETRYING  = 3'd4
	} conn_state_t;

	typedef struct packed {
		logic [CfgWidth-1:0] backoff_min;
		logic [CfgWidth-1:0] backoff_max;
		logic [CfgWidth-1:0] first_data;
		logic [CfgWidth-1:0] disconnect;
	} cfg_t;

endpackage

/* design/lwb_regs.sv */
// APB-style configuration registers of the link watchdog.
// Depends on lwb_pkg for the register map and the cfg_t struct.
module lwb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lwb_pkg::AddrWidth-1:0]  paddr,
	input  logic [lwb_pkg::DataWidth-1:0]  pwdata,
	output logic [lwb_pkg::DataWidth-1:0]  prdata,
	output logic                           pready,
	output lwb_pkg::cfg_t                  cfg
);
	import lwb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backoff_min <= BackoffMinRst;
			cfg_q.backoff_max <= BackoffMaxRst;
			cfg_q.first_data  <= FirstDataRst;
			cfg_q.disconnect  <= DisconnRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_BACKOFF_MIN: cfg_q.backoff_min <= pwdata[CfgWidth-1:0];
				REG_BACKOFF_MAX: cfg_q.backoff_max <= pwdata[CfgWidth-1:0];
				REG_FIRST_DATA:  cfg_q.first_data  <= pwdata[CfgWidth-1:0];
				REG_DISCONNECT:  cfg_q.disconnect  <= pwdata[CfgWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BACKOFF_MIN: prdata = {{(DataWidth-CfgWidth){1'b0}}, cfg_q.backoff_min};
			REG_BACKOFF_MAX: prdata = {{(DataWidth-CfgWidth){1'b0}}, cfg_q.backoff_max};
			REG_FIRST_DATA:  prdata = {{(DataWidth-CfgWidth){1'b0}}, cfg_q.first_data};
			REG_DISCONNECT:  prdata = {{(DataWidth-CfgWidth){1'b0}}, cfg_q.disconnect};
			default:         prdata = '0;
		endcase
	end

endmodule

/* design/lwb_core.sv */
// Watchdog state registers and the combinational event update logic.
// Depends on lwb_pkg for the state, opcode and configuration types.
module lwb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  lwb_pkg::op_t                   op,
	input  logic [lwb_pkg::TimeWidth-1:0]  now,
	input  logic                           tx,
	input  lwb_pkg::cfg_t                  cfg,
	output logic                           action_nxt,
	output lwb_pkg::conn_state_t           state_nxt
);
	import lwb_pkg::*;

	conn_state_t          state_q;
	logic [TimeWidth-1:0] since_q, last_q, next_try_q;
	logic [CfgWidth-1:0]  backoff_q;
	logic [CntWidth-1:0]  attempt_q;
	logic                 fresh_q;

	logic [TimeWidth-1:0] since_n, last_n, next_try_n;
	logic [CfgWidth-1:0]  backoff_n;
	logic [CntWidth-1:0]  attempt_n;
	logic                 fresh_n;

	logic                 first_expired, disc_expired, retry_due;
	logic [CfgWidth:0]    doubled;
	logic [CfgWidth-1:0]  backoff_clamped;
	logic [TimeWidth+1:0] deadline;

	// Elapsed time counts as zero when the clock appears to run backwards.
	function automatic logic elapsed_ge(input logic [TimeWidth-1:0] t,
	                                    input logic [TimeWidth-1:0] ref_t,
	                                    input logic [CfgWidth-1:0] lim);
		logic [TimeWidth-1:0] d;
		d = (t >= ref_t) ? (t - ref_t) : '0;
		return d >= {{(TimeWidth-CfgWidth){1'b0}}, lim};
	endfunction

	assign first_expired   = elapsed_ge(now, since_q, cfg.first_data);
	assign disc_expired    = elapsed_ge(now, last_q, cfg.disconnect);
	assign retry_due       = now >= next_try_q;
	assign doubled         = {backoff_q, 1'b0};
	assign backoff_clamped = (doubled > {1'b0, cfg.backoff_max}) ? cfg.backoff_max
	                                                              : doubled[CfgWidth-1:0];
	assign deadline        = {2'b00, now}
	                       + {{(TimeWidth+2-CfgWidth){1'b0}}, cfg.first_data}
	                       + {{(TimeWidth+2-CfgWidth){1'b0}}, backoff_clamped};

	always_comb begin
		state_nxt  = state_q;
		since_n    = since_q;
		last_n     = last_q;
		next_try_n = next_try_q;
		backoff_n  = backoff_q;
		attempt_n  = attempt_q;
		fresh_n    = fresh_q;
		action_nxt = 1'b0;
		unique case (op)
			OP_TICK: begin
				if (state_q == ST_IDLE) begin
					action_nxt = 1'b0;
				end else if (tx && (state_q == ST_STREAMING || state_q == ST_STARTING)) begin
					// A keyed transmitter counts as link activity.
					last_n  = now;
					since_n = now;
				end else begin
					unique case (state_q)
						ST_STARTING: begin
							if (fresh_q) begin
								backoff_n = cfg.backoff_min;
								attempt_n = '0;
								state_nxt = ST_STREAMING;
								since_n   = now;
								fresh_n   = 1'b0;
							end else if (first_expired) begin
								state_nxt = ST_LOST;
								since_n   = now;
								fresh_n   = 1'b0;
								if (attempt_q == '0) begin
									next_try_n = now;
								end
							end
						end
						ST_STREAMING: begin
							if (disc_expired) begin
								state_nxt  = ST_LOST;
								since_n    = now;
								fresh_n    = 1'b0;
								next_try_n = now;
							end
						end
						ST_LOST: begin
							if (fresh_q) begin
								backoff_n = cfg.backoff_min;
								attempt_n = '0;
								state_nxt = ST_STREAMING;
								since_n   = now;
								fresh_n   = 1'b0;
							end else if (retry_due) begin
								state_nxt  = ST_RETRYING;
								since_n    = now;
								fresh_n    = 1'b0;
								action_nxt = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			OP_RESET: begin
				last_n     = now;
				next_try_n = '0;
				backoff_n  = cfg.backoff_min;
				attempt_n  = '0;
				state_nxt  = ST_STARTING;
				since_n    = now;
				fresh_n    = 1'b0;
			end
			OP_RETRY: begin
				next_try_n = now;
				if (state_q == ST_STARTING) begin
					state_nxt = ST_LOST;
					since_n   = now;
					fresh_n   = 1'b0;
				end
			end
			OP_ATTEMPT: begin
				if (attempt_q != '1) begin
					attempt_n = attempt_q + 1'b1;
				end
				last_n     = now;
				backoff_n  = backoff_clamped;
				next_try_n = (deadline[TimeWidth+1:TimeWidth] != 2'b00) ? '1
				                                                       : deadline[TimeWidth-1:0];
				state_nxt  = ST_STARTING;
				since_n    = now;
				fresh_n    = 1'b0;
			end
			OP_DATA: begin
				fresh_n = 1'b1;
				last_n  = now;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			since_q    <= '0;
			last_q     <= '0;
			next_try_q <= '0;
			backoff_q  <= BackoffMinRst;
			attempt_q  <= '0;
			fresh_q    <= 1'b0;
		end else if (step) begin
			state_q    <= state_nxt;
			since_q    <= since_n;
			last_q     <= last_n;
			next_try_q <= next_try_n;
			backoff_q  <= backoff_n;
			attempt_q  <= attempt_n;
			fresh_q    <= fresh_n;
		end
	end

endmodule

/* design/link_watchdog_backoff_core.sv */
// Top level of the link watchdog with exponential reconnect backoff.
// Depends on lwb_pkg, lwb_regs and lwb_core.
//
// Usage: each input item is one event (opcode, now, transmitting) offered
// on in_valid/in_ready. Every event yields exactly one result item (action,
// conn_state) on out_valid/out_ready, in order. An accepted event lands in
// an input register; the watchdog state is then updated from it and the
// result is written to the output register once that register is free or
// being emptied. One event is taken every cycle while results drain.
// If the receiver stalls, the result stays in the output register and one
// more event waits in the input register, after which in_ready drops until
// the result is taken.
// The user must write configuration through the APB-style port only while
// no event is in flight; the block itself does not enforce this. Reset
// clears the pipeline, puts the link in the idle state and loads the
// register defaults (backoff 1..60 s, first data 10 s, disconnect 3 s).
module link_watchdog_backoff_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     opcode,
	input  logic [lwb_pkg::TimeWidth-1:0]  now,
	input  logic                           transmitting,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           action,
	output logic [2:0]                     conn_state,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lwb_pkg::AddrWidth-1:0]  paddr,
	input  logic [lwb_pkg::DataWidth-1:0]  pwdata,
	output logic [lwb_pkg::DataWidth-1:0]  prdata,
	output logic                           pready
);
	import lwb_pkg::*;

	cfg_t                 cfg;
	logic                 valid_s1;
	op_t                  op_s1;
	logic [TimeWidth-1:0] now_s1;
	logic                 tx_s1;
	logic                 advance;
	logic                 action_nxt;
	conn_state_t          state_nxt;
	logic                 out_valid_q;
	logic                 action_q;
	conn_state_t          conn_state_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	lwb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op_t'(opcode);
			now_s1 <= now;
			tx_s1  <= transmitting;
		end
	end

	lwb_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.op         (op_s1),
		.now        (now_s1),
		.tx         (tx_s1),
		.cfg        (cfg),
		.action_nxt (action_nxt),
		.state_nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q     <= action_nxt;
			conn_state_q <= state_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = action_q;
	assign conn_state = conn_state_q;

	// A reconnect request is only ever issued on entry to the retrying state.
	a_action_retrying: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action_q |-> conn_state_q == ST_RETRYING)
		else $error("action raised outside the retrying state");

	// An accepted item always occupies the input register on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item missing from input register");

	// A stalled output keeps the queued item in place.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |=> valid_s1 && $stable(now_s1))
		else $error("queued item lost during output stall");

	// Nothing enters the output register without an item to work on.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !out_valid_q |=> !out_valid_q)
		else $error("result produced without an item");

endmodule
